// ----- rtl/dclt_pkg.sv -----
// ----------------------------------------------------------------------------
// dclt_pkg: shared types and constants for the debounced cue latch
// Input modes, register map, configuration bundle and the request format of
// the shared subtract-and-compare unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dclt_pkg;

   // input item modes
   localparam logic [1:0] MODE_SCAN    = 2'd0;
   localparam logic [1:0] MODE_TRIGGER = 2'd1;
   localparam logic [1:0] MODE_RELEASE = 2'd2;

   // register map: word index taken from paddr[2]
   localparam int         CSR_ADDR_W   = 3;
   localparam logic       REG_DEBOUNCE = 1'b0;
   localparam logic       REG_AUTO     = 1'b1;

   localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
   localparam logic [23:0] AUTO_RESET     = 24'd0;

   typedef struct packed {
      logic [15:0] debounce_ms;
      logic [23:0] auto_release_ms;
   } cfg_type;

   // elapsed = minuend - subtrahend (wrapping), compared against limit
   typedef struct packed {
      logic [31:0] minuend;
      logic [31:0] subtrahend;
      logic [31:0] limit;
   } cmp_req_type;

endpackage

`default_nettype wire

// ----- rtl/dclt_if.sv -----
// ----------------------------------------------------------------------------
// dclt_if: valid/ready channels of the debounced cue latch
// Input channel carries scan or manual items, result channel carries one
// state change per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface dclt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [3:0]  button_levels;
   logic [3:0]  cue_index;
   logic [31:0] now_ms;

   modport source (output valid, mode, button_levels, cue_index, now_ms, input ready);
   modport sink   (input valid, mode, button_levels, cue_index, now_ms, output ready);
endinterface

interface dclt_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] changed_cue;
   logic       now_active;
   logic [3:0] led_bits;
   logic       last_change;

   modport source (output valid, changed_cue, now_active, led_bits, last_change,
                   input ready);
   modport sink   (input valid, changed_cue, now_active, led_bits, last_change,
                   output ready);
endinterface

`default_nettype wire

// ----- rtl/dclt_csr.sv -----
// ----------------------------------------------------------------------------
// dclt_csr: configuration registers
// APB-style write and read of the debounce and auto-release times.
// ----------------------------------------------------------------------------
`default_nettype none

module dclt_csr (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               csr_psel,
   input  wire                               csr_penable,
   input  wire                               csr_pwrite,
   input  wire  [dclt_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire  [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready,
   output dclt_pkg::cfg_type                 cfg
);

   dclt_pkg::cfg_type cfg_ff, cfg_in;
   logic              wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_paddr[2])
            dclt_pkg::REG_DEBOUNCE: cfg_in.debounce_ms     = csr_pwdata[15:0];
            dclt_pkg::REG_AUTO:     cfg_in.auto_release_ms = csr_pwdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         dclt_pkg::REG_DEBOUNCE: csr_prdata = 32'(cfg_ff.debounce_ms);
         dclt_pkg::REG_AUTO:     csr_prdata = 32'(cfg_ff.auto_release_ms);
         default:                csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms     <= dclt_pkg::DEBOUNCE_RESET;
         cfg_ff.auto_release_ms <= dclt_pkg::AUTO_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/dclt_cmp.sv -----
// ----------------------------------------------------------------------------
// dclt_cmp: shared elapsed-time comparator
// Wrapping 32-bit subtraction followed by an unsigned at-least compare.
// ----------------------------------------------------------------------------
`default_nettype none

module dclt_cmp (
   input  dclt_pkg::cmp_req_type cmp_req,
   output logic                  elapsed
);

   logic [31:0] diff;

   assign diff    = cmp_req.minuend - cmp_req.subtrahend;
   assign elapsed = (diff >= cmp_req.limit);

endmodule

`default_nettype wire

// ----- rtl/dclt_core.sv -----
// ----------------------------------------------------------------------------
// dclt_core: channel sequencer and cue state
// Scan items: each channel in turn, a debounce step then an auto-release step,
// both through the shared comparator; manual items visit one cue. Changes are
// staged so that the final one of an item can be flagged before it leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module dclt_core #(
   parameter int CUE_COUNT = 4
) (
   input  wire                    clock,
   input  wire                    reset,
   input  dclt_pkg::cfg_type      cfg,
   dclt_req_if.sink               req,
   dclt_rsp_if.source             rsp,
   output dclt_pkg::cmp_req_type  cmp_req,
   input  wire                    cmp_elapsed
);

   localparam int IDX_W = (CUE_COUNT > 1) ? $clog2(CUE_COUNT) : 1;
   localparam logic [IDX_W-1:0] LAST_CH = IDX_W'(CUE_COUNT - 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DEB   = 3'd1;
   localparam logic [2:0] S_AUTO  = 3'd2;
   localparam logic [2:0] S_MAN   = 3'd3;
   localparam logic [2:0] S_FLUSH = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [IDX_W-1:0]      ch_ff, ch_in;
   logic [3:0]            levels_ff, levels_in;
   logic [31:0]           now_ff, now_in;
   logic                  act_req_ff, act_req_in;
   logic                  idx_ok_ff, idx_ok_in;

   logic [CUE_COUNT-1:0]  active_ff, active_in;
   logic [CUE_COUNT-1:0]  seen_ff, seen_in;
   logic [31:0]           cstamp_ff [CUE_COUNT];
   logic [31:0]           cstamp_in [CUE_COUNT];
   logic [31:0]           bstamp_ff [CUE_COUNT];
   logic [31:0]           bstamp_in [CUE_COUNT];

   logic                  pend_valid_ff, pend_valid_in;
   logic [3:0]            pend_cue_ff, pend_cue_in;
   logic                  pend_act_ff, pend_act_in;
   logic [3:0]            pend_led_ff, pend_led_in;

   logic                  out_valid_ff, out_valid_in;
   logic [3:0]            out_cue_ff, out_cue_in;
   logic                  out_act_ff, out_act_in;
   logic [3:0]            out_led_ff, out_led_in;
   logic                  out_last_ff, out_last_in;

   logic [15:0]           lvl_ext;
   logic [15:0]           lvl_shift;
   logic                  level;
   logic                  cur_act;
   logic                  cur_seen;
   logic                  deb_take;
   logic                  chg;
   logic                  new_act;
   logic [CUE_COUNT-1:0]  new_vec;
   logic [15:0]           led_ext;
   logic                  can_push;
   logic                  stall;
   logic                  advance;

   assign req.ready       = (state_ff == S_IDLE);
   assign rsp.valid       = out_valid_ff;
   assign rsp.changed_cue = out_cue_ff;
   assign rsp.now_active  = out_act_ff;
   assign rsp.led_bits    = out_led_ff;
   assign rsp.last_change = out_last_ff;

   // channels without a button bit read as released
   assign lvl_ext   = {12'hfff, levels_ff};
   assign lvl_shift = lvl_ext >> ch_ff;
   assign level     = lvl_shift[0];
   assign cur_act   = active_ff[ch_ff];
   assign cur_seen  = seen_ff[ch_ff];

   always_comb begin
      cmp_req.minuend = now_ff;
      if (state_ff == S_AUTO) begin
         cmp_req.subtrahend = cstamp_ff[ch_ff];
         cmp_req.limit      = 32'(cfg.auto_release_ms);
      end else begin
         cmp_req.subtrahend = bstamp_ff[ch_ff];
         cmp_req.limit      = 32'(cfg.debounce_ms);
      end
   end

   assign deb_take = (state_ff == S_DEB) && (level != cur_seen) && cmp_elapsed;

   always_comb begin
      chg     = 1'b0;
      new_act = 1'b0;
      case (state_ff)
         S_DEB: begin
            new_act = !level;
            chg     = deb_take && (cur_act != !level);
         end
         S_AUTO: begin
            new_act = 1'b0;
            chg     = cur_act && (cfg.auto_release_ms != 24'd0) && cmp_elapsed;
         end
         S_MAN: begin
            new_act = act_req_ff;
            chg     = idx_ok_ff && (cur_act != act_req_ff);
         end
         default: ;
      endcase
   end

   always_comb begin
      new_vec        = active_ff;
      new_vec[ch_ff] = new_act;
   end
   assign led_ext = 16'(new_vec);

   assign can_push = !out_valid_ff || rsp.ready;
   // hold while a staged change has nowhere to go
   assign stall    = pend_valid_ff && !can_push && (chg || (state_ff == S_FLUSH));
   assign advance  = !stall;

   always_comb begin
      state_in      = state_ff;
      ch_in         = ch_ff;
      levels_in     = levels_ff;
      now_in        = now_ff;
      act_req_in    = act_req_ff;
      idx_ok_in     = idx_ok_ff;
      active_in     = active_ff;
      seen_in       = seen_ff;
      cstamp_in     = cstamp_ff;
      bstamp_in     = bstamp_ff;
      pend_valid_in = pend_valid_ff;
      pend_cue_in   = pend_cue_ff;
      pend_act_in   = pend_act_ff;
      pend_led_in   = pend_led_ff;
      out_valid_in  = out_valid_ff && !rsp.ready;
      out_cue_in    = out_cue_ff;
      out_act_in    = out_act_ff;
      out_led_in    = out_led_ff;
      out_last_in   = out_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               levels_in  = req.button_levels;
               now_in     = req.now_ms;
               act_req_in = (req.mode == dclt_pkg::MODE_TRIGGER);
               idx_ok_in  = (32'(req.cue_index) < CUE_COUNT);
               ch_in      = '0;
               case (req.mode)
                  dclt_pkg::MODE_SCAN: state_in = S_DEB;
                  dclt_pkg::MODE_TRIGGER,
                  dclt_pkg::MODE_RELEASE: begin
                     state_in = S_MAN;
                     if (32'(req.cue_index) < CUE_COUNT) begin
                        ch_in = req.cue_index[IDX_W-1:0];
                     end
                  end
                  default: state_in = S_FLUSH;
               endcase
            end
         end
         S_DEB: begin
            if (advance) begin
               if (deb_take) begin
                  seen_in[ch_ff]   = level;
                  bstamp_in[ch_ff] = now_ff;
               end
               state_in = S_AUTO;
            end
         end
         S_AUTO: begin
            if (advance) begin
               if (ch_ff == LAST_CH) begin
                  state_in = S_FLUSH;
               end else begin
                  ch_in    = ch_ff + IDX_W'(1);
                  state_in = S_DEB;
               end
            end
         end
         S_MAN: begin
            if (advance) begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            if (advance) begin
               // release the staged change as the final one of this item
               if (pend_valid_ff) begin
                  out_valid_in  = 1'b1;
                  out_cue_in    = pend_cue_ff;
                  out_act_in    = pend_act_ff;
                  out_led_in    = pend_led_ff;
                  out_last_in   = 1'b1;
                  pend_valid_in = 1'b0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (chg && advance) begin
         active_in[ch_ff] = new_act;
         cstamp_in[ch_ff] = now_ff;
         // a newer change proves the staged one is not the last
         if (pend_valid_ff) begin
            out_valid_in = 1'b1;
            out_cue_in   = pend_cue_ff;
            out_act_in   = pend_act_ff;
            out_led_in   = pend_led_ff;
            out_last_in  = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_cue_in   = 4'(ch_ff);
         pend_act_in   = new_act;
         pend_led_in   = led_ext[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         ch_ff         <= '0;
         active_ff     <= '0;
         seen_ff       <= '1;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         for (int i = 0; i < CUE_COUNT; i++) begin
            cstamp_ff[i] <= 32'd0;
            bstamp_ff[i] <= 32'd0;
         end
      end else begin
         state_ff      <= state_in;
         ch_ff         <= ch_in;
         active_ff     <= active_in;
         seen_ff       <= seen_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         cstamp_ff     <= cstamp_in;
         bstamp_ff     <= bstamp_in;
      end
   end

   always_ff @(posedge clock) begin
      levels_ff   <= levels_in;
      now_ff      <= now_in;
      act_req_ff  <= act_req_in;
      idx_ok_ff   <= idx_ok_in;
      pend_cue_ff <= pend_cue_in;
      pend_act_ff <= pend_act_in;
      pend_led_ff <= pend_led_in;
      out_cue_ff  <= out_cue_in;
      out_act_ff  <= out_act_in;
      out_led_ff  <= out_led_in;
      out_last_ff <= out_last_in;
   end

endmodule

`default_nettype wire

// ----- rtl/debounced_cue_latch_with_timeout.sv -----
// Scan item: one step to take the item, two comparator steps per channel (debounce,
// auto release) and one to flag the last result. Trigger or release item: take,
// one manual step, flag. Steps are held only while the result register is full.
// A result may wait in the output register while the next item is taken.
// Synchronous reset: all cues inactive, buttons released, stamps zero,
// debounce 50 ms, auto release disabled.
// ----------------------------------------------------------------------------
// debounced_cue_latch_with_timeout: top level
// Lockout debouncer for active-low cue buttons with optional auto release,
// built around one shared elapsed-time comparator under a channel sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module debounced_cue_latch_with_timeout #(
   parameter int CUE_COUNT = 4
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               csr_psel,
   input  wire                               csr_penable,
   input  wire                               csr_pwrite,
   input  wire  [dclt_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire  [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready,
   dclt_req_if.sink                          req_chan,
   dclt_rsp_if.source                        rsp_chan
);

   dclt_pkg::cfg_type     cfg;
   dclt_pkg::cmp_req_type cmp_req;
   logic                  cmp_elapsed;

   dclt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   dclt_cmp u_cmp (
      .cmp_req (cmp_req),
      .elapsed (cmp_elapsed)
   );

   dclt_core #(
      .CUE_COUNT (CUE_COUNT)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req         (req_chan),
      .rsp         (rsp_chan),
      .cmp_req     (cmp_req),
      .cmp_elapsed (cmp_elapsed)
   );

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for debounced_cue_latch_with_timeout
// Drives scan, trigger and release items with random gaps and back-pressure.
// Each result transfer is compared with a cycle-free model of the cue latch.
// Debounce and auto-release settings are swept through their extremes.
// ----------------------------------------------------------------------------
module tb;

   localparam int          CUE_N       = 4;
   localparam int          ADDR_W      = dclt_pkg::CSR_ADDR_W;
   localparam int          CYCLE_LIMIT = 300000;
   localparam int          SETTLE      = 16;
   localparam int          PHASE_ITEMS = 62;
   localparam logic [1:0]  MODE_SPARE  = 2'd3;

   typedef struct packed {
      logic [1:0]  mode;
      logic [3:0]  levels;
      logic [3:0]  cue;
      logic [31:0] stamp;
   } cue_item_type;

   typedef struct packed {
      logic [3:0] cue;
      logic       on;
      logic [3:0] leds;
      logic       last;
   } cue_change_type;

   // known_n/known_* hold a hand-worked outcome where it is obvious
   typedef struct packed {
      logic [1:0]  mode;
      logic [3:0]  levels;
      logic [3:0]  cue;
      logic [31:0] stamp;
      logic        known;
      logic [2:0]  known_n;
      logic [3:0]  known_cue;
      logic        known_on;
      logic [3:0]  known_leds;
   } probe_row_type;

   localparam probe_row_type PROBES [18] = '{
      '{dclt_pkg::MODE_SCAN,    4'hF,    4'd0,  32'd0,         1'b1, 3'd0, 4'd0, 1'b0, 4'b0000},
      '{dclt_pkg::MODE_TRIGGER, 4'h0,    4'd0,  32'd10,        1'b1, 3'd1, 4'd0, 1'b1, 4'b0001},
      '{dclt_pkg::MODE_TRIGGER, 4'h0,    4'd0,  32'd11,        1'b1, 3'd0, 4'd0, 1'b0, 4'b0000},
      '{dclt_pkg::MODE_RELEASE, 4'h0,    4'd0,  32'd20,        1'b1, 3'd1, 4'd0, 1'b0, 4'b0000},
      '{dclt_pkg::MODE_RELEASE, 4'h0,    4'd0,  32'd21,        1'b1, 3'd0, 4'd0, 1'b0, 4'b0000},
      '{dclt_pkg::MODE_TRIGGER, 4'hF,    4'd15, 32'd22,        1'b1, 3'd0, 4'd0, 1'b0, 4'b0000},
      '{dclt_pkg::MODE_RELEASE, 4'h0,    4'd4,  32'd23,        1'b1, 3'd0, 4'd0, 1'b0, 4'b0000},
      '{MODE_SPARE,             4'h0,    4'd0,  32'd24,        1'b1, 3'd0, 4'd0, 1'b0, 4'b0000},
      '{dclt_pkg::MODE_SCAN,    4'h0,    4'd0,  32'd30,        1'b1, 3'd0, 4'd0, 1'b0, 4'b0000},
      '{dclt_pkg::MODE_SCAN,    4'h0,    4'd0,  32'd50,        1'b0, 3'd0, 4'd0, 1'b0, 4'b0000},
      '{dclt_pkg::MODE_SCAN,    4'hF,    4'd0,  32'd60,        1'b1, 3'd0, 4'd0, 1'b0, 4'b0000},
      '{dclt_pkg::MODE_SCAN,    4'b1110, 4'd0,  32'd100,       1'b0, 3'd0, 4'd0, 1'b0, 4'b0000},
      '{dclt_pkg::MODE_TRIGGER, 4'h0,    4'd2,  32'd101,       1'b1, 3'd1, 4'd2, 1'b1, 4'b0101},
      '{dclt_pkg::MODE_SCAN,    4'hF,    4'd0,  32'hFFFF_FFFF, 1'b0, 3'd0, 4'd0, 1'b0, 4'b0000},
      '{dclt_pkg::MODE_SCAN,    4'h0,    4'd0,  32'h0000_0010, 1'b0, 3'd0, 4'd0, 1'b0, 4'b0000},
      '{dclt_pkg::MODE_SCAN,    4'h0,    4'd0,  32'h0000_0031, 1'b0, 3'd0, 4'd0, 1'b0, 4'b0000},
      '{dclt_pkg::MODE_RELEASE, 4'h0,    4'd3,  32'h0000_0040, 1'b1, 3'd1, 4'd3, 1'b0, 4'b0111},
      '{dclt_pkg::MODE_SCAN,    4'b1010, 4'd7,  32'h0000_0050, 1'b0, 3'd0, 4'd0, 1'b0, 4'b0000}
   };

   localparam logic [15:0] PHASE_DEBOUNCE [4] = '{16'd0, 16'd65535, 16'd20, 16'd1000};
   localparam logic [23:0] PHASE_AUTO     [4] = '{24'd1, 24'd16777215, 24'd100, 24'd0};
   localparam int unsigned PHASE_STEP     [4] = '{3, 40000, 60, 1500};
   localparam logic [31:0] PHASE_START    [4] =
      '{32'd1000, 32'hFFF0_0000, 32'h8000_0000, 32'hFFFF_FF00};

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [ADDR_W-1:0] csr_paddr;
   logic [31:0]       csr_pwdata;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   dclt_req_if req_bus();
   dclt_rsp_if rsp_bus();

   debounced_cue_latch_with_timeout #(.CUE_COUNT(CUE_N)) DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus)
   );

   // latch model state
   logic [CUE_N-1:0] lamp;
   logic [31:0]      lit_since [CUE_N];
   logic [CUE_N-1:0] level_held;
   logic [31:0]      level_since [CUE_N];
   logic [15:0]      hold_off_ms;
   logic [23:0]      release_after_ms;

   cue_change_type item_changes[$];
   cue_change_type due_changes[$];

   bit          failed;
   bit          steady;
   int unsigned cycles;
   logic [31:0] clock_ms;
   logic [3:0]  level_pattern;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void set_lamp(input int unsigned n, input logic on,
                                    input logic [31:0] at);
      cue_change_type c;
      if (n >= CUE_N || lamp[n] == on) return;
      lamp[n]      = on;
      lit_since[n] = at;
      c.cue  = 4'(n);
      c.on   = on;
      c.leds = 4'(lamp);
      c.last = 1'b0;
      item_changes.push_back(c);
   endfunction

   function automatic void predict_item(input cue_item_type it);
      logic [31:0]    gap;
      logic           lvl;
      cue_change_type tail;
      item_changes.delete();
      case (it.mode)
         dclt_pkg::MODE_SCAN: begin
            // level first, then the auto-release test, channel by channel
            for (int i = 0; i < CUE_N; i++) begin
               lvl = (i < 4) ? it.levels[i] : 1'b1;
               gap = it.stamp - level_since[i];
               if (lvl != level_held[i] && gap >= 32'(hold_off_ms)) begin
                  level_held[i]  = lvl;
                  level_since[i] = it.stamp;
                  set_lamp(i, !lvl, it.stamp);
               end
               gap = it.stamp - lit_since[i];
               if (lamp[i] && release_after_ms != 0 && gap >= 32'(release_after_ms))
                  set_lamp(i, 1'b0, it.stamp);
            end
         end
         dclt_pkg::MODE_TRIGGER: set_lamp(it.cue, 1'b1, it.stamp);
         dclt_pkg::MODE_RELEASE: set_lamp(it.cue, 1'b0, it.stamp);
         default: ;
      endcase
      if (item_changes.size() != 0) begin
         tail = item_changes.pop_back();
         tail.last = 1'b1;
         item_changes.push_back(tail);
      end
   endfunction

   // mostly orderly scans with advancing time, some noise and manual items
   function automatic cue_item_type draw_item(input int unsigned step_max);
      cue_item_type it;
      int unsigned  pick;
      pick = $urandom_range(99);
      if ($urandom_range(19) == 0)
         clock_ms = clock_ms + $urandom;
      else
         clock_ms = clock_ms + $urandom_range(step_max);
      it.stamp  = clock_ms;
      it.levels = 4'($urandom);
      it.cue    = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                          : 4'($urandom_range(CUE_N - 1));
      if (pick < 72) begin
         it.mode = dclt_pkg::MODE_SCAN;
         for (int b = 0; b < 4; b++)
            if ($urandom_range(3) == 0) level_pattern[b] = ~level_pattern[b];
         if ($urandom_range(9) == 0) level_pattern = 4'($urandom);
         it.levels = level_pattern;
      end else if (pick < 85) begin
         it.mode = dclt_pkg::MODE_TRIGGER;
      end else if (pick < 97) begin
         it.mode = dclt_pkg::MODE_RELEASE;
      end else begin
         it.mode = MODE_SPARE;
      end
      return it;
   endfunction

   task automatic offer_item(input cue_item_type it);
      while (!steady && $urandom_range(99) < 11) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.mode          <= it.mode;
      req_bus.button_levels <= it.levels;
      req_bus.cue_index     <= it.cue;
      req_bus.now_ms        <= it.stamp;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_item(it);
      foreach (item_changes[k]) due_changes.push_back(item_changes[k]);
      @(negedge clock);
   endtask

   // hold the input idle until every change has come out and the block settles
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (due_changes.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(input logic which, input logic [31:0] value);
      logic [31:0] readback;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_W'({which, 2'b00});
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      readback = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (which == dclt_pkg::REG_DEBOUNCE)
         hold_off_ms = value[15:0];
      else
         release_after_ms = value[23:0];
      if (readback !== value) begin
         $display("%0t: register %0d read back: expected %h, got %h",
                  $time, which, value, readback);
         failed = 1'b1;
      end
   endtask

   always @(negedge clock) begin
      rsp_bus.ready <= steady || ($urandom_range(99) >= 11);
   end

   always @(posedge clock) begin
      cue_change_type got;
      cue_change_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = {rsp_bus.changed_cue, rsp_bus.now_active, rsp_bus.led_bits,
                rsp_bus.last_change};
         if (due_changes.size() == 0) begin
            $display("%0t: unexpected transfer: cue %0d on %b leds %b last %b",
                     $time, got.cue, got.on, got.leds, got.last);
            failed = 1'b1;
         end else begin
            want = due_changes.pop_front();
            if (got !== want) begin
               $display("%0t: expected cue/on/leds/last %0d/%b/%b/%b, got %0d/%b/%b/%b",
                        $time, want.cue, want.on, want.leds, want.last,
                        got.cue, got.on, got.leds, got.last);
               failed = 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("debounced_cue_latch_with_timeout: mismatch");
         $finish;
      end
   end

   initial begin
      cue_item_type  it;
      probe_row_type row;
      cycles                = 0;
      failed                = 1'b0;
      steady                = 1'b0;
      reset                 = 1'b1;
      csr_psel              = 1'b0;
      csr_penable           = 1'b0;
      csr_pwrite            = 1'b0;
      csr_paddr             = '0;
      csr_pwdata            = '0;
      req_bus.valid         = 1'b0;
      req_bus.mode          = dclt_pkg::MODE_SCAN;
      req_bus.button_levels = 4'hF;
      req_bus.cue_index     = 4'd0;
      req_bus.now_ms        = 32'd0;
      rsp_bus.ready         = 1'b0;
      lamp                  = '0;
      level_held            = '1;
      hold_off_ms           = dclt_pkg::DEBOUNCE_RESET;
      release_after_ms      = dclt_pkg::AUTO_RESET;
      level_pattern         = 4'hF;
      for (int i = 0; i < CUE_N; i++) begin
         lit_since[i]   = 32'd0;
         level_since[i] = 32'd0;
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (PROBES[p]) begin
         row = PROBES[p];
         it  = {row.mode, row.levels, row.cue, row.stamp};
         offer_item(it);
         if (row.known && (item_changes.size() != row.known_n ||
             (row.known_n != 0 &&
              item_changes[0] !== {row.known_cue, row.known_on, row.known_leds, 1'b1}))) begin
            $display("%0t: item %0d: expected %0d change(s) cue %0d on %b leds %b, got %0d",
                     $time, p, row.known_n, row.known_cue, row.known_on,
                     row.known_leds, item_changes.size());
            failed = 1'b1;
         end
      end

      for (int p = 0; p < 4; p++) begin
         drain();
         csr_write(dclt_pkg::REG_DEBOUNCE, 32'(PHASE_DEBOUNCE[p]));
         csr_write(dclt_pkg::REG_AUTO, 32'(PHASE_AUTO[p]));
         clock_ms = PHASE_START[p];
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // one long stretch with neither side idling
            steady = (p == 2 && n < 40);
            offer_item(draw_item(PHASE_STEP[p]));
         end
         steady = 1'b0;
      end

      drain();
      if (!failed && due_changes.size() == 0)
         $display("debounced_cue_latch_with_timeout: match");
      else
         $display("debounced_cue_latch_with_timeout: mismatch");
      $finish;
   end

endmodule
